/* hdl/u8esc_pkg.sv */
// Shared types, constants and microcode table for the UTF-8 code point escaper.
`default_nettype none

package u8esc_pkg;

    localparam int STEP_W     = 4;
    localparam int ACC_W      = 31;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int CNT_W      = 5;

    typedef logic [STEP_W-1:0] step_t;

    // Microprogram addresses
    localparam step_t STEP_FETCH     = 4'd0;
    localparam step_t STEP_DECODE    = 4'd1;
    localparam step_t STEP_TERM_DONE = 4'd2;
    localparam step_t STEP_TERM_E1   = 4'd3;
    localparam step_t STEP_TERM_E2   = 4'd4;
    localparam step_t STEP_BAD       = 4'd5;
    localparam step_t STEP_CONV      = 4'd6;
    localparam step_t STEP_DD        = 4'd7;
    localparam step_t STEP_USC1      = 4'd8;
    localparam step_t STEP_SKIP      = 4'd9;
    localparam step_t STEP_DIGIT     = 4'd10;
    localparam step_t STEP_USC2      = 4'd11;
    localparam step_t STEP_PASS      = 4'd12;

    localparam logic [CNT_W-1:0] DD_STEPS   = 5'd31;
    localparam logic [CNT_W-1:0] DIG_COUNT  = 5'd10;

    localparam logic [7:0] CHAR_US   = 8'd95;
    localparam logic [7:0] CHAR_ZERO = 8'd48;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEAD = 2'd1;
    localparam logic [1:0] ST_CUT      = 2'd2;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_LATCH,
        UOP_DECODE,
        UOP_BCD_INIT,
        UOP_DD_STEP,
        UOP_DIG_INIT,
        UOP_SKIP,
        UOP_DIG_SHIFT
    } uop_t;

    typedef enum logic [2:0] {
        JC_GOTO,
        JC_DISPATCH,
        JC_WAIT_IN,
        JC_IF_PASS,
        JC_LOOP_CNT,
        JC_LOOP_SKIP
    } jc_t;

    typedef enum logic [1:0] {
        CH_NONE,
        CH_US,
        CH_VAL,
        CH_DIGIT
    } chsel_t;

    typedef struct packed {
        logic   in_rdy;
        logic   emit;
        chsel_t chsel;
        logic   eos;
        logic   last;
        logic   set_emitted;
        logic   clr_emitted;
        uop_t   uop;
        jc_t    jc;
        step_t  target;
    } ctrl_t;

    typedef struct packed {
        logic  go;
        logic  in_fire;
        logic  pass;
        logic  cnt_one;
        logic  skip_more;
        step_t dispatch;
    } flags_t;

    function automatic ctrl_t ucode_rom(input step_t addr);
        ctrl_t c;
        c        = '0;
        c.chsel  = CH_NONE;
        c.uop    = UOP_NOP;
        c.jc     = JC_GOTO;
        c.target = STEP_FETCH;
        case (addr)
            STEP_FETCH:
            begin
                c.in_rdy = 1'b1;
                c.uop    = UOP_LATCH;
                c.jc     = JC_WAIT_IN;
                c.target = STEP_DECODE;
            end
            STEP_DECODE:
            begin
                c.uop = UOP_DECODE;
                c.jc  = JC_DISPATCH;
            end
            STEP_TERM_DONE:
            begin
                c.emit        = 1'b1;
                c.eos         = 1'b1;
                c.last        = 1'b1;
                c.clr_emitted = 1'b1;
            end
            STEP_TERM_E1:
            begin
                c.emit   = 1'b1;
                c.chsel  = CH_US;
                c.target = STEP_TERM_E2;
            end
            STEP_TERM_E2:
            begin
                c.emit        = 1'b1;
                c.chsel       = CH_US;
                c.eos         = 1'b1;
                c.last        = 1'b1;
                c.clr_emitted = 1'b1;
            end
            STEP_BAD:
            begin
                c.emit = 1'b1;
                c.last = 1'b1;
            end
            STEP_CONV:
            begin
                c.uop    = UOP_BCD_INIT;
                c.jc     = JC_IF_PASS;
                c.target = STEP_PASS;
            end
            STEP_DD:
            begin
                c.uop    = UOP_DD_STEP;
                c.jc     = JC_LOOP_CNT;
                c.target = STEP_USC1;
            end
            STEP_USC1:
            begin
                c.emit        = 1'b1;
                c.chsel       = CH_US;
                c.set_emitted = 1'b1;
                c.uop         = UOP_DIG_INIT;
                c.target      = STEP_SKIP;
            end
            STEP_SKIP:
            begin
                c.uop    = UOP_SKIP;
                c.jc     = JC_LOOP_SKIP;
                c.target = STEP_DIGIT;
            end
            STEP_DIGIT:
            begin
                c.emit   = 1'b1;
                c.chsel  = CH_DIGIT;
                c.uop    = UOP_DIG_SHIFT;
                c.jc     = JC_LOOP_CNT;
                c.target = STEP_USC2;
            end
            STEP_USC2:
            begin
                c.emit  = 1'b1;
                c.chsel = CH_US;
                c.last  = 1'b1;
            end
            STEP_PASS:
            begin
                c.emit        = 1'b1;
                c.chsel       = CH_VAL;
                c.last        = 1'b1;
                c.set_emitted = 1'b1;
            end
            default:
            begin
                c.jc     = JC_GOTO;
                c.target = STEP_FETCH;
            end
        endcase
        return c;
    endfunction

    // '+', '-', digits and letters pass through unescaped
    function automatic logic is_plain(input logic [ACC_W-1:0] v);
        logic r;
        r = 1'b0;
        if (v inside {31'd43, 31'd45, [31'd48:31'd57], [31'd65:31'd90], [31'd97:31'd122]})
        begin
            r = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/u8esc_sequencer.sv */
// Microprogram step counter, control store lookup and jump logic.
`default_nettype none

module u8esc_sequencer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire u8esc_pkg::flags_t flags,
    output u8esc_pkg::ctrl_t     ctrl
);

    u8esc_pkg::step_t step_reg;
    u8esc_pkg::step_t step_next;

    assign ctrl = u8esc_pkg::ucode_rom(step_reg);

    always_comb
    begin
        step_next = step_reg;
        if (flags.go)
        begin
            case (ctrl.jc)
                u8esc_pkg::JC_GOTO:      step_next = ctrl.target;
                u8esc_pkg::JC_DISPATCH:  step_next = flags.dispatch;
                u8esc_pkg::JC_WAIT_IN:   step_next = flags.in_fire ? ctrl.target : step_reg;
                u8esc_pkg::JC_IF_PASS:   step_next = flags.pass ? ctrl.target
                                                                : step_reg + 1'b1;
                u8esc_pkg::JC_LOOP_CNT:  step_next = flags.cnt_one ? ctrl.target : step_reg;
                u8esc_pkg::JC_LOOP_SKIP: step_next = flags.skip_more ? step_reg : ctrl.target;
                default:                 step_next = u8esc_pkg::STEP_FETCH;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= u8esc_pkg::STEP_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/u8esc_datapath.sv */
// Decode registers, binary-to-decimal shifter and output register driven by the microcode.
`default_nettype none

module u8esc_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire u8esc_pkg::ctrl_t  ctrl,
    output u8esc_pkg::flags_t      flags,
    input  wire logic              cfg_valid,
    input  wire logic              utf_mode,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        in_byte,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_char,
    output logic                   char_valid,
    output logic                   run_last,
    output logic                   end_of_string,
    output logic [1:0]             status
);

    localparam int AW = u8esc_pkg::ACC_W;
    localparam int BW = u8esc_pkg::BCD_W;
    localparam int CW = u8esc_pkg::CNT_W;

    logic                   utf_mode_reg;
    logic [7:0]             byte_reg;
    logic [2:0]             pend_reg;
    logic [AW-1:0]          acc_reg;
    logic                   emitted_reg;
    logic [AW-1:0]          val_reg;
    logic [BW-1:0]          bcd_reg;
    logic [CW-1:0]          cnt_reg;
    logic [1:0]             st_reg;

    logic                   out_valid_reg;
    logic [7:0]             out_char_reg;
    logic                   char_valid_reg;
    logic                   run_last_reg;
    logic                   eos_reg;
    logic [1:0]             status_reg;

    logic [2:0]             pend_next;
    logic [AW-1:0]          acc_next;
    logic [AW-1:0]          val_next;
    logic [1:0]             st_next;
    u8esc_pkg::step_t       dispatch;
    u8esc_pkg::step_t       term_step;
    logic [AW-1:0]          acc_shift;
    logic [BW-1:0]          bcd_adj;
    logic [3:0]             top_digit;
    logic                   go;
    logic                   in_fire;
    logic [7:0]             ch;
    logic                   ch_valid;

    assign in_ready  = ctrl.in_rdy;
    assign in_fire   = ctrl.in_rdy && in_valid;
    assign go        = !ctrl.emit || !out_valid_reg || out_ready;
    assign top_digit = bcd_reg[BW-1 -: 4];
    assign acc_shift = {acc_reg[AW-7:0], byte_reg[5:0]};
    assign term_step = emitted_reg ? u8esc_pkg::STEP_TERM_DONE : u8esc_pkg::STEP_TERM_E1;

    assign flags.go        = go;
    assign flags.in_fire   = in_fire;
    assign flags.pass      = u8esc_pkg::is_plain(val_reg);
    assign flags.cnt_one   = (cnt_reg == CW'(1));
    assign flags.skip_more = (top_digit == 4'd0) && (cnt_reg != CW'(1));
    assign flags.dispatch  = dispatch;

    // Classify the latched byte against the sequence state
    always_comb
    begin
        pend_next = pend_reg;
        acc_next  = acc_reg;
        val_next  = val_reg;
        st_next   = u8esc_pkg::ST_OK;
        dispatch  = u8esc_pkg::STEP_FETCH;
        if (pend_reg != 3'd0)
        begin
            if (byte_reg == 8'd0)
            begin
                pend_next = 3'd0;
                acc_next  = '0;
                st_next   = u8esc_pkg::ST_CUT;
                dispatch  = term_step;
            end
            else
            begin
                pend_next = pend_reg - 3'd1;
                if (pend_reg == 3'd1)
                begin
                    val_next = acc_shift;
                    acc_next = '0;
                    dispatch = u8esc_pkg::STEP_CONV;
                end
                else
                begin
                    acc_next = acc_shift;
                end
            end
        end
        else if (byte_reg == 8'd0)
        begin
            dispatch = term_step;
        end
        else if (!utf_mode_reg || byte_reg <= 8'h7F)
        begin
            val_next = {{(AW-8){1'b0}}, byte_reg};
            dispatch = u8esc_pkg::STEP_CONV;
        end
        else if (byte_reg <= 8'hDF)
        begin
            acc_next  = {{(AW-5){1'b0}}, byte_reg[4:0]};
            pend_next = 3'd1;
        end
        else if (byte_reg <= 8'hEF)
        begin
            acc_next  = {{(AW-4){1'b0}}, byte_reg[3:0]};
            pend_next = 3'd2;
        end
        else if (byte_reg <= 8'hF7)
        begin
            acc_next  = {{(AW-3){1'b0}}, byte_reg[2:0]};
            pend_next = 3'd3;
        end
        else if (byte_reg <= 8'hFB)
        begin
            acc_next  = {{(AW-2){1'b0}}, byte_reg[1:0]};
            pend_next = 3'd4;
        end
        else if (byte_reg <= 8'hFD)
        begin
            acc_next  = {{(AW-1){1'b0}}, byte_reg[0]};
            pend_next = 3'd5;
        end
        else
        begin
            st_next  = u8esc_pkg::ST_BAD_LEAD;
            dispatch = u8esc_pkg::STEP_BAD;
        end
    end

    // Add 3 to every BCD digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < u8esc_pkg::BCD_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                             : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        case (ctrl.chsel)
            u8esc_pkg::CH_NONE:
            begin
                ch       = 8'd0;
                ch_valid = 1'b0;
            end
            u8esc_pkg::CH_US:
            begin
                ch       = u8esc_pkg::CHAR_US;
                ch_valid = 1'b1;
            end
            u8esc_pkg::CH_VAL:
            begin
                ch       = val_reg[7:0];
                ch_valid = 1'b1;
            end
            u8esc_pkg::CH_DIGIT:
            begin
                ch       = u8esc_pkg::CHAR_ZERO + {4'd0, top_digit};
                ch_valid = 1'b1;
            end
            default:
            begin
                ch       = 8'd0;
                ch_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utf_mode_reg  <= 1'b0;
            pend_reg      <= 3'd0;
            acc_reg       <= '0;
            emitted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                utf_mode_reg <= utf_mode;
            end
            if (go && ctrl.uop == u8esc_pkg::UOP_DECODE)
            begin
                pend_reg <= pend_next;
                acc_reg  <= acc_next;
            end
            if (go && ctrl.set_emitted)
            begin
                emitted_reg <= 1'b1;
            end
            else if (go && ctrl.clr_emitted)
            begin
                emitted_reg <= 1'b0;
            end
            if (go && ctrl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            case (ctrl.uop)
                u8esc_pkg::UOP_LATCH:
                begin
                    if (in_fire)
                    begin
                        byte_reg <= in_byte;
                    end
                end
                u8esc_pkg::UOP_DECODE:
                begin
                    val_reg <= val_next;
                    st_reg  <= st_next;
                end
                u8esc_pkg::UOP_BCD_INIT:
                begin
                    bcd_reg <= '0;
                    cnt_reg <= u8esc_pkg::DD_STEPS;
                end
                u8esc_pkg::UOP_DD_STEP:
                begin
                    bcd_reg <= {bcd_adj[BW-2:0], val_reg[AW-1]};
                    val_reg <= {val_reg[AW-2:0], 1'b0};
                    cnt_reg <= cnt_reg - CW'(1);
                end
                u8esc_pkg::UOP_DIG_INIT:
                begin
                    cnt_reg <= u8esc_pkg::DIG_COUNT;
                end
                u8esc_pkg::UOP_SKIP:
                begin
                    // drop leading zeros, keep at least one digit
                    if (flags.skip_more)
                    begin
                        bcd_reg <= {bcd_reg[BW-5:0], 4'd0};
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end
                u8esc_pkg::UOP_DIG_SHIFT:
                begin
                    bcd_reg <= {bcd_reg[BW-5:0], 4'd0};
                    cnt_reg <= cnt_reg - CW'(1);
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
            if (ctrl.emit)
            begin
                out_char_reg   <= ch;
                char_valid_reg <= ch_valid;
                run_last_reg   <= ctrl.last;
                eos_reg        <= ctrl.eos;
                status_reg     <= st_reg;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_char      = out_char_reg;
    assign char_valid    = char_valid_reg;
    assign run_last      = run_last_reg;
    assign end_of_string = eos_reg;
    assign status        = status_reg;

    a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd5)
        else $error("pending byte count out of range");

    a_digit_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        (go && ctrl.emit && ctrl.chsel == u8esc_pkg::CH_DIGIT) |-> top_digit <= 4'd9)
        else $error("emitted digit is not decimal");

    a_nochar_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !char_valid_reg) |-> run_last_reg)
        else $error("character-less result not last of its byte");

    a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && eos_reg) |-> run_last_reg)
        else $error("string close not on last result");

endmodule

`default_nettype wire

/* hdl/utf8_codepoint_escaper_unit.sv */
// Top level of the UTF-8 code point escaper: sequencer plus datapath.
// Flow: each byte is taken in FETCH and classified in DECODE; a pass-through character
// is emitted from PASS, while an escaped code point runs CONV, the 31-step shift-add-3 loop,
// an underscore, the leading-zero skip, its decimal digits and a closing underscore.
// A new byte is taken only once the microprogram is back in FETCH; output stalls hold the flow.
// Reset: rst_n clears the step counter, sequence state, mode and output valid at once.
`default_nettype none

module utf8_codepoint_escaper_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       utf_mode,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_char,
    output logic            char_valid,
    output logic            run_last,
    output logic            end_of_string,
    output logic [1:0]      status
);

    u8esc_pkg::ctrl_t  ctrl;
    u8esc_pkg::flags_t flags;

    assign cfg_ready = 1'b1;

    u8esc_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    u8esc_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .flags         (flags),
        .cfg_valid     (cfg_valid),
        .utf_mode      (utf_mode),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_char      (out_char),
        .char_valid    (char_valid),
        .run_last      (run_last),
        .end_of_string (end_of_string),
        .status        (status)
    );

endmodule

`default_nettype wire
